@@ design/i2cm_pkg.sv @@
// Package for the I2C master bit engine: payload types, configuration
// register type, widths and reset values. No dependencies.
package i2cm_pkg;

  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned POLL_W     = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd1;

  // Configuration reset values
  localparam logic [DELAY_W-1:0] HALF_PERIOD_RST = 16'd48;
  localparam logic [POLL_W-1:0]  ACK_TIMEOUT_RST = 8'd250;

  // One bus tick offered to the engine
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  // Line levels and status reported for one tick
  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } result_t;

  // Configuration register contents
  typedef struct packed {
    logic [DELAY_W-1:0] half_period_ticks;
    logic [POLL_W-1:0]  ack_timeout;
  } cfg_t;

endpackage

@@ design/i2cm_cmd_if.sv @@
// Valid/ready channel carrying one bus tick item into the engine.
// Depends on i2cm_pkg.
interface i2cm_cmd_if;
  logic                valid;
  logic                ready;
  i2cm_pkg::item_t     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/i2cm_res_if.sv @@
// Valid/ready channel carrying one tick result out of the engine.
// Depends on i2cm_pkg.
interface i2cm_res_if;
  logic                valid;
  logic                ready;
  i2cm_pkg::result_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/i2cm_core.sv @@
// Bus sequencer of the I2C master: phase register, delay, bit and poll
// counters, line levels. Advances one tick per step. Depends on i2cm_pkg.
module i2cm_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  i2cm_pkg::item_t   item,
  input  i2cm_pkg::cfg_t    cfg,
  output i2cm_pkg::result_t res
);
  import i2cm_pkg::*;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_START_A = 4'd1;
  localparam logic [3:0] PH_START_B = 4'd2;
  localparam logic [3:0] PH_STOP_A  = 4'd3;
  localparam logic [3:0] PH_STOP_B  = 4'd4;
  localparam logic [3:0] PH_WR_A    = 4'd5;
  localparam logic [3:0] PH_WR_B    = 4'd6;
  localparam logic [3:0] PH_WR_C    = 4'd7;
  localparam logic [3:0] PH_WA_REL  = 4'd8;
  localparam logic [3:0] PH_WA_HIGH = 4'd9;
  localparam logic [3:0] PH_WA_POLL = 4'd10;
  localparam logic [3:0] PH_RD_LOW  = 4'd11;
  localparam logic [3:0] PH_RD_HIGH = 4'd12;
  localparam logic [3:0] PH_RK_A    = 4'd13;
  localparam logic [3:0] PH_RK_B    = 4'd14;

  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_WAIT  = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  logic [3:0]         phase_r, phase_nxt;
  logic [2:0]         cmd_r, cmd_nxt;
  logic [DELAY_W-1:0] delay_r, delay_nxt;
  logic [3:0]         bit_r, bit_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [POLL_W-1:0]  poll_r, poll_nxt;
  logic               ack_choice_r, ack_choice_nxt;
  logic               scl_r, scl_nxt;
  logic               sdao_r, sdao_nxt;
  logic               drv_r, drv_nxt;
  logic [7:0]         rx_r, rx_nxt;
  logic               fail_r, fail_nxt;
  logic               done;

  logic [DELAY_W-1:0] delay_load;
  logic [DELAY_W-1:0] delay_dec;
  logic [3:0]         bit_inc;

  // A zero half period behaves as one tick
  assign delay_load = (cfg.half_period_ticks == '0) ? {{(DELAY_W-1){1'b0}}, 1'b1}
                                                    : cfg.half_period_ticks;
  assign delay_dec  = (delay_r != '0) ? delay_r - 1'b1 : '0;
  assign bit_inc    = bit_r + 1'b1;

  // Next state for one tick
  always_comb begin
    phase_nxt      = phase_r;
    cmd_nxt        = cmd_r;
    delay_nxt      = delay_r;
    bit_nxt        = bit_r;
    shift_nxt      = shift_r;
    poll_nxt       = poll_r;
    ack_choice_nxt = ack_choice_r;
    scl_nxt        = scl_r;
    sdao_nxt       = sdao_r;
    drv_nxt        = drv_r;
    rx_nxt         = rx_r;
    fail_nxt       = fail_r;
    done           = 1'b0;

    if (phase_r == PH_IDLE) begin
      // Take a new command; unknown kinds are dropped
      if (item.cmd_valid && item.kind <= CMD_READ) begin
        cmd_nxt   = item.kind;
        delay_nxt = delay_load;
        unique case (item.kind)
          CMD_START: begin
            phase_nxt = PH_START_A;
            {scl_nxt, sdao_nxt, drv_nxt} = 3'b111;
          end
          CMD_STOP: begin
            phase_nxt = PH_STOP_A;
            {scl_nxt, sdao_nxt, drv_nxt} = 3'b001;
          end
          CMD_WRITE: begin
            bit_nxt   = '0;
            shift_nxt = {item.tx_byte[6:0], 1'b0};
            phase_nxt = PH_WR_A;
            {scl_nxt, sdao_nxt, drv_nxt} = {1'b0, item.tx_byte[7], 1'b1};
          end
          CMD_WAIT: begin
            poll_nxt  = '0;
            phase_nxt = PH_WA_REL;
            {scl_nxt, sdao_nxt, drv_nxt} = {scl_r, 1'b1, 1'b0};
          end
          default: begin
            ack_choice_nxt = item.send_ack;
            shift_nxt      = '0;
            bit_nxt        = '0;
            phase_nxt      = PH_RD_LOW;
            {scl_nxt, sdao_nxt, drv_nxt} = 3'b010;
          end
        endcase
      end
    end else if (phase_r == PH_WA_POLL || (phase_r == PH_WA_HIGH && delay_dec == '0)) begin
      // Poll SDA for the acknowledge
      phase_nxt = PH_WA_POLL;
      delay_nxt = delay_dec;
      if (phase_r == PH_WA_POLL) delay_nxt = delay_r;
      if (!item.sda_in) begin
        {scl_nxt, sdao_nxt, drv_nxt} = 3'b010;
        fail_nxt  = 1'b0;
        phase_nxt = PH_IDLE;
        done      = 1'b1;
      end else if (poll_r >= cfg.ack_timeout) begin
        phase_nxt = PH_STOP_A;
        delay_nxt = delay_load;
        {scl_nxt, sdao_nxt, drv_nxt} = 3'b001;
      end else begin
        poll_nxt = poll_r + 1'b1;
      end
    end else begin
      // Count down the delay, then advance the phase
      delay_nxt = delay_dec;
      if (delay_dec == '0) begin
        unique case (phase_r)
          PH_START_A: begin
            phase_nxt = PH_START_B;
            delay_nxt = delay_load;
            {scl_nxt, sdao_nxt, drv_nxt} = 3'b101;
          end
          PH_START_B: begin
            {scl_nxt, sdao_nxt, drv_nxt} = 3'b001;
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
          PH_STOP_A: begin
            phase_nxt = PH_STOP_B;
            delay_nxt = delay_load;
            {scl_nxt, sdao_nxt, drv_nxt} = 3'b111;
          end
          PH_STOP_B: begin
            if (cmd_r == CMD_WAIT) fail_nxt = 1'b1;
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
          PH_WR_A: begin
            phase_nxt = PH_WR_B;
            delay_nxt = delay_load;
            {scl_nxt, sdao_nxt, drv_nxt} = {1'b1, sdao_r, 1'b1};
          end
          PH_WR_B: begin
            phase_nxt = PH_WR_C;
            delay_nxt = delay_load;
            {scl_nxt, sdao_nxt, drv_nxt} = {1'b0, sdao_r, 1'b1};
          end
          PH_WR_C: begin
            bit_nxt = bit_inc;
            if (bit_inc >= BITS_PER_BYTE) begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end else begin
              shift_nxt = {shift_r[6:0], 1'b0};
              phase_nxt = PH_WR_A;
              delay_nxt = delay_load;
              {scl_nxt, sdao_nxt, drv_nxt} = {1'b0, shift_r[7], 1'b1};
            end
          end
          PH_WA_REL: begin
            phase_nxt = PH_WA_HIGH;
            delay_nxt = delay_load;
            {scl_nxt, sdao_nxt, drv_nxt} = 3'b110;
          end
          PH_RD_LOW: begin
            phase_nxt = PH_RD_HIGH;
            delay_nxt = delay_load;
            {scl_nxt, sdao_nxt, drv_nxt} = 3'b110;
            shift_nxt = {shift_r[6:0], item.sda_in};
          end
          PH_RD_HIGH: begin
            bit_nxt   = bit_inc;
            delay_nxt = delay_load;
            if (bit_inc >= BITS_PER_BYTE) begin
              phase_nxt = PH_RK_A;
              {scl_nxt, sdao_nxt, drv_nxt} = {1'b0, ~ack_choice_r, 1'b1};
            end else begin
              phase_nxt = PH_RD_LOW;
              {scl_nxt, sdao_nxt, drv_nxt} = 3'b010;
            end
          end
          PH_RK_A: begin
            phase_nxt = PH_RK_B;
            delay_nxt = delay_load;
            {scl_nxt, sdao_nxt, drv_nxt} = {1'b1, sdao_r, 1'b1};
          end
          PH_RK_B: begin
            {scl_nxt, sdao_nxt, drv_nxt} = {1'b0, sdao_r, 1'b1};
            rx_nxt    = shift_r;
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Result of the tick shows the state after it
  always_comb begin
    res.scl        = scl_nxt;
    res.sda_out    = sdao_nxt;
    res.sda_drive  = drv_nxt;
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.done_res   = done;
    res.rx_byte    = rx_nxt;
    res.ack_failed = fail_nxt;
  end

  // Hold state between steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      cmd_r        <= CMD_START;
      delay_r      <= '0;
      bit_r        <= '0;
      shift_r      <= '0;
      poll_r       <= '0;
      ack_choice_r <= 1'b0;
      scl_r        <= 1'b1;
      sdao_r       <= 1'b1;
      drv_r        <= 1'b1;
      rx_r         <= '0;
      fail_r       <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      cmd_r        <= cmd_nxt;
      delay_r      <= delay_nxt;
      bit_r        <= bit_nxt;
      shift_r      <= shift_nxt;
      poll_r       <= poll_nxt;
      ack_choice_r <= ack_choice_nxt;
      scl_r        <= scl_nxt;
      sdao_r       <= sdao_nxt;
      drv_r        <= drv_nxt;
      rx_r         <= rx_nxt;
      fail_r       <= fail_nxt;
    end
  end

  // While SDA is released, its output level is always high
  a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
    !drv_r |-> sdao_r)
    else $error("SDA released while driven level is low");

  // Bit counter never passes one byte
  a_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= BITS_PER_BYTE)
    else $error("bit counter overran a byte");

  // A completing tick leaves the engine idle next cycle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && done |=> phase_r == PH_IDLE)
    else $error("engine not idle after done");

endmodule

@@ design/i2c_master_bit_engine.sv @@
// Top level of the I2C master bit engine: input register, result register,
// configuration registers. Depends on i2cm_pkg, i2cm_cmd_if, i2cm_res_if, i2cm_core.
//
// Each transfer on in_ch is one tick of the bus sequencer and yields exactly one
// transfer on out_ch with the line levels and status after that tick. The block
// takes one item per cycle while out_ch is not stalled: an item waits in the input
// register, the sequencer in i2cm_core advances by one tick, and the result lands
// in the output register; a stalled output holds back only the input register.
// Bus timing counts ticks, not clock cycles: each bus step lasts half_period_ticks
// items (zero acts as one). Write configuration only while the engine is idle and
// no items are in flight.
module i2c_master_bit_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  i2cm_cmd_if.sink                            in_ch,
  i2cm_res_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import i2cm_pkg::*;

  item_t   item_r;
  logic    in_vld_r;
  result_t res_r;
  logic    out_vld_r;
  cfg_t    cfg_r;
  result_t core_res;
  logic    step;

  // Advance the sequencer when an item waits and the output can take it
  assign step         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || step;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = res_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_ticks <= HALF_PERIOD_RST;
      cfg_r.ack_timeout       <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_HALF_PERIOD: cfg_r.half_period_ticks <= cfg_wdata;
        default:         cfg_r.ack_timeout       <= cfg_wdata[POLL_W-1:0];
      endcase
    end
  end

  // Input register: load on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) item_r <= in_ch.data;
  end

  // Output register: load on each step, drop on output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= step || (out_vld_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (step) res_r <= core_res;
  end

  i2cm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg_r),
    .res   (core_res)
  );

  // A waiting item is never dropped while the output stalls
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !step |=> in_vld_r)
    else $error("input item lost while stalled");

  // Every step produces a result next cycle
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_vld_r)
    else $error("step without a result");

  // A done result always shows the engine no longer busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.done_res |-> !res_r.busy_res)
    else $error("done reported while busy");

endmodule
